/* design/sha1md_pkg.sv */
`timescale 1ns / 1ps

package sha1md_pkg;

	// Initial chaining value h0..h4
	localparam logic [31:0] H_INIT [0:4] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// Round constants, one per group of twenty rounds
	localparam logic [31:0] K_CH   = 32'h5A827999;
	localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
	localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam int ROUNDS    = 80;
	localparam int ROUND_W   = 7;
	localparam int WORD_SEL_W = 3;
	localparam logic [WORD_SEL_W-1:0] LAST_WORD = 3'd4;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_of_message;
	} sha1md_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} sha1md_out_t;

	// Round function group
	typedef enum logic [1:0] {
		PH_CH,
		PH_PAR1,
		PH_MAJ,
		PH_PAR2
	} phase_t;

	// Source of the byte written into the block
	typedef enum logic [1:0] {
		SRC_MSG,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_ADD,
		S_PAD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                  write_byte;
		byte_src_t             src;
		logic                  count_msg;
		logic                  load_vars;
		logic                  round_en;
		phase_t                phase;
		logic                  add_chain;
		logic [WORD_SEL_W-1:0] out_sel;
		logic                  restart;
	} sha1md_cmd_t;

	typedef struct packed {
		logic pos_end;   // write position is the last byte of the block
		logic pos_tail;  // write position is in the length field
	} sha1md_stat_t;

endpackage

/* design/sha1md_dp.sv */
`timescale 1ns / 1ps

module sha1md_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sha1md_pkg::sha1md_in_t   in_data,
	input  sha1md_pkg::sha1md_cmd_t  cmd,
	output sha1md_pkg::sha1md_stat_t stat,
	output sha1md_pkg::sha1md_out_t  out_data
);
	import sha1md_pkg::*;

	logic [31:0] block_q [0:15];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] chain_q [0:4];
	logic [60:0] count_q;
	logic [5:0]  pos_q;

	logic [63:0] bit_len;
	logic [63:0] len_shift;
	logic [7:0]  wr_byte;
	logic [1:0]  lane;
	logic [31:0] w_mix;
	logic [31:0] w_next;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;

	// Pick the byte to store: message, marker, zero or length
	assign bit_len   = {count_q, 3'b000};
	assign len_shift = bit_len << {pos_q[2:0], 3'b000};
	always_comb begin
		case (cmd.src)
			SRC_MSG:  wr_byte = in_data.msg_byte;
			SRC_MARK: wr_byte = PAD_MARK;
			SRC_ZERO: wr_byte = 8'h00;
			SRC_LEN:  wr_byte = len_shift[63:56];
			default:  wr_byte = 8'h00;
		endcase
	end

	// Big-endian lane within the word
	assign lane = ~pos_q[1:0];

	// Next schedule word from the window taps
	assign w_mix  = block_q[13] ^ block_q[8] ^ block_q[2] ^ block_q[0];
	assign w_next = {w_mix[30:0], w_mix[31]};

	// Block store: byte writes while filling, window shift while compressing
	always_ff @(posedge clk) begin
		if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				block_q[i] <= block_q[i+1];
			end
			block_q[15] <= w_next;
		end else if (cmd.write_byte) begin
			block_q[pos_q[5:2]][{lane, 3'b000} +: 8] <= wr_byte;
		end
	end

	// Round function and constant
	always_comb begin
		case (cmd.phase)
			PH_CH: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				k_val = K_CH;
			end
			PH_PAR1: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K_PAR1;
			end
			PH_MAJ: begin
				f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k_val = K_MAJ;
			end
			PH_PAR2: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K_PAR2;
			end
			default: begin
				f_val = 32'h0;
				k_val = 32'h0;
			end
		endcase
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + block_q[0];

	// Working variables: load from chain, then one round per cycle
	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round_en) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t_val;
		end
	end

	// Chaining value: fold in the compressed block, restart per message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else if (cmd.restart) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else if (cmd.add_chain) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	// Advance write position and message byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
		end else if (cmd.restart) begin
			pos_q   <= '0;
			count_q <= '0;
		end else if (cmd.write_byte) begin
			pos_q <= pos_q + 6'd1;
			if (cmd.count_msg) begin
				count_q <= count_q + 61'd1;
			end
		end
	end

	assign stat.pos_end  = &pos_q;
	assign stat.pos_tail = &pos_q[5:3];

	// Present the selected digest word
	always_comb begin
		out_data.digest_last = (cmd.out_sel == LAST_WORD);
		case (cmd.out_sel)
			3'd0:    out_data.digest_word = chain_q[0];
			3'd1:    out_data.digest_word = chain_q[1];
			3'd2:    out_data.digest_word = chain_q[2];
			3'd3:    out_data.digest_word = chain_q[3];
			3'd4:    out_data.digest_word = chain_q[4];
			default: out_data.digest_word = 32'h0;
		endcase
	end

endmodule

/* design/sha1md_ctrl.sv */
`timescale 1ns / 1ps

module sha1md_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  sha1md_pkg::sha1md_in_t   in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  sha1md_pkg::sha1md_stat_t stat,
	output sha1md_pkg::sha1md_cmd_t  cmd
);
	import sha1md_pkg::*;

	state_t                state_q, state_d;
	logic [ROUND_W-1:0]    round_q, round_d;
	logic [WORD_SEL_W-1:0] word_q, word_d;
	logic                  end_q, end_d;
	logic                  pad_q, pad_d;
	logic                  first_q, first_d;
	logic                  len_ok_q, len_ok_d;

	// Hold state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			round_q  <= '0;
			word_q   <= '0;
			end_q    <= 1'b0;
			pad_q    <= 1'b0;
			first_q  <= 1'b0;
			len_ok_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			round_q  <= round_d;
			word_q   <= word_d;
			end_q    <= end_d;
			pad_q    <= pad_d;
			first_q  <= first_d;
			len_ok_q <= len_ok_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		round_d  = round_q;
		word_d   = word_q;
		end_d    = end_q;
		pad_d    = pad_q;
		first_d  = first_q;
		len_ok_d = len_ok_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;

		cmd            = '0;
		cmd.src        = SRC_MSG;
		cmd.out_sel    = word_q;
		if (round_q < ROUND_W'(20)) begin
			cmd.phase = PH_CH;
		end else if (round_q < ROUND_W'(40)) begin
			cmd.phase = PH_PAR1;
		end else if (round_q < ROUND_W'(60)) begin
			cmd.phase = PH_MAJ;
		end else begin
			cmd.phase = PH_PAR2;
		end

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.byte_present) begin
						cmd.write_byte = 1'b1;
						cmd.count_msg  = 1'b1;
						cmd.src        = SRC_MSG;
						if (stat.pos_end) begin
							cmd.load_vars = 1'b1;
							end_d   = in_data.end_of_message;
							state_d = S_ROUND;
						end else if (in_data.end_of_message) begin
							pad_d   = 1'b1;
							first_d = 1'b1;
							state_d = S_PAD;
						end
					end else if (in_data.end_of_message) begin
						pad_d   = 1'b1;
						first_d = 1'b1;
						state_d = S_PAD;
					end
				end
			end
			S_ROUND: begin
				cmd.round_en = 1'b1;
				if (round_q == ROUND_W'(ROUNDS - 1)) begin
					round_d = '0;
					state_d = S_ADD;
				end else begin
					round_d = round_q + ROUND_W'(1);
				end
			end
			S_ADD: begin
				cmd.add_chain = 1'b1;
				if (pad_q) begin
					if (len_ok_q) begin
						state_d = S_OUT;
					end else begin
						len_ok_d = 1'b1;
						state_d  = S_PAD;
					end
				end else if (end_q) begin
					end_d   = 1'b0;
					pad_d   = 1'b1;
					first_d = 1'b1;
					state_d = S_PAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_PAD: begin
				// Write marker first, then zeros, then the length field
				cmd.write_byte = 1'b1;
				if (first_q) begin
					cmd.src  = SRC_MARK;
					first_d  = 1'b0;
					len_ok_d = ~stat.pos_tail;
				end else if (len_ok_q && stat.pos_tail) begin
					cmd.src = SRC_LEN;
				end else begin
					cmd.src = SRC_ZERO;
				end
				if (stat.pos_end) begin
					cmd.load_vars = 1'b1;
					state_d = S_ROUND;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (word_q == LAST_WORD) begin
						cmd.restart = 1'b1;
						word_d   = '0;
						pad_d    = 1'b0;
						len_ok_d = 1'b0;
						state_d  = S_IDLE;
					end else begin
						word_d = word_q + WORD_SEL_W'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output handshakes open together");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (round_q < ROUND_W'(ROUNDS)))
		else $error("round counter past last round");

	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (word_q <= LAST_WORD))
		else $error("digest word select out of range");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && word_q == LAST_WORD) |=> (state_q == S_IDLE))
		else $error("no return to idle after last digest word");

	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && $past(state_q) != S_ROUND) |-> (round_q == '0))
		else $error("compression started at nonzero round");
`endif

endmodule

/* design/sha1_message_digest.sv */
`timescale 1ns / 1ps

// SHA-1 hash of a byte stream. Send one byte per request with byte_present
// set; set end_of_message on the last request (byte_present may be 0 there,
// which also allows an empty message). Message bytes are taken one per cycle
// until a 64-byte block fills; the byte that fills it starts a compression of
// 80 rounds, one per cycle on a single round unit, after which the result is
// folded into the chaining value. No input is taken while a block compresses.
// After the end request, padding is written one byte per cycle up to the
// block end (a second block of padding when the length no longer fits), with
// one or two compressions, then the five digest words h0..h4 come out, h4 with
// digest_last set. The block is ready for the next message once h4 is taken.

module sha1_message_digest (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  sha1md_pkg::sha1md_in_t  in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output sha1md_pkg::sha1md_out_t out_data
);
	import sha1md_pkg::*;

	sha1md_cmd_t  cmd;
	sha1md_stat_t stat;

	sha1md_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sha1md_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule
